/* src/md5_pkg.sv */
package md5_pkg;

    // Kind of a queued transaction, decided by the front end
    typedef enum logic {
        ITEM_ABSORB = 1'b0,
        ITEM_FINISH = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  data_byte;
    } item_t;

    // Queue between front end and compression engine
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Block buffer: 16 little-endian words of four bytes
    localparam int BLOCK_WORDS = 16;
    localparam int STEPS       = 64;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Standard initial chaining values A, B, C, D
    localparam logic [31:0] INIT_WORDS [4] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
    };

    // Per-step additive constants
    localparam logic [31:0] STEP_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Message word used by a step
    function automatic logic [3:0] word_sel(input logic [5:0] step);
        logic [3:0] j;
        logic [3:0] g;
        j = step[3:0];
        unique case (step[5:4])
            2'd0:    g = j;
            2'd1:    g = j * 4'd5 + 4'd1;
            2'd2:    g = j * 4'd3 + 4'd5;
            default: g = j * 4'd7;
        endcase
        return g;
    endfunction

    // Left rotation amount of a step
    function automatic logic [4:0] rot_amount(input logic [5:0] step);
        logic [4:0] s;
        unique case ({step[5:4], step[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

/* src/md5_front.sv */
module md5_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [7:0]       s_data_byte,
    output logic             q_valid,
    output md5_pkg::item_t   q_item,
    input  logic             q_pop
);

    localparam int AW = md5_pkg::QUEUE_AW;

    md5_pkg::item_t     slot_reg [md5_pkg::QUEUE_DEPTH];
    logic [AW-1:0]      wr_ptr_reg;
    logic [AW-1:0]      rd_ptr_reg;
    logic [AW:0]        fill_reg;
    logic               push;
    logic               pop;
    md5_pkg::item_t     new_item;

    // Classify the incoming transaction
    always_comb begin
        new_item.kind      = s_action ? md5_pkg::ITEM_FINISH : md5_pkg::ITEM_ABSORB;
        new_item.data_byte = s_data_byte;
    end

    assign s_ready = (fill_reg != (AW+1)'(md5_pkg::QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    // Queue storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    // Queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

/* src/md5_back.sv */
module md5_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  md5_pkg::item_t   q_item,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_digest_word,
    output logic [1:0]       m_word_index,
    output logic             m_last_word
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FINAL
    } state_t;

    state_t         state_reg;
    logic [31:0]    chain_reg [4];
    logic [31:0]    work_reg  [4];
    logic [60:0]    count_reg;
    logic [6:0]     step_reg;
    logic [3:0]     pad_word_reg;
    logic [1:0]     pad_lane_reg;
    logic           pad_first_reg;
    logic           len_blk_reg;
    logic           need_second_reg;
    logic           fin_reg;
    logic [31:0]    out_word_reg [4];
    logic [1:0]     out_idx_reg;
    logic           out_valid_reg;

    // Block buffer memory with byte-lane writes
    logic [31:0]    buf_mem [md5_pkg::BLOCK_WORDS];
    logic [31:0]    rdata_reg;
    logic [3:0]     mem_we;
    logic [3:0]     mem_waddr;
    logic [31:0]    mem_wdata;
    logic [3:0]     mem_raddr;

    logic [5:0]     pos;
    logic [63:0]    bit_len;
    logic [5:0]     sidx;
    logic [31:0]    f_val;
    logic [31:0]    t_val;
    logic [63:0]    rot_wide;
    logic [31:0]    sum_word [4];
    logic           take;
    logic           take_absorb;

    assign pos     = count_reg[5:0];
    assign bit_len = {count_reg, 3'b000};

    // Absorbs go on while a digest drains; a finish waits for the output to clear
    assign q_pop = (state_reg == ST_IDLE) && q_valid &&
                   ((q_item.kind == md5_pkg::ITEM_ABSORB) || !out_valid_reg);
    assign take        = q_pop;
    assign take_absorb = q_pop && (q_item.kind == md5_pkg::ITEM_ABSORB);

    // Buffer write: stored byte, or one word of padding / length
    always_comb begin
        mem_we    = '0;
        mem_waddr = pad_word_reg;
        mem_wdata = '0;
        if (take_absorb) begin
            mem_waddr      = pos[5:2];
            mem_we[pos[1:0]] = 1'b1;
            mem_wdata      = {4{q_item.data_byte}};
        end else if (state_reg == ST_PAD) begin
            if (len_blk_reg && pad_word_reg == 4'd14) begin
                mem_we    = '1;
                mem_wdata = bit_len[31:0];
            end else if (len_blk_reg && pad_word_reg == 4'd15) begin
                mem_we    = '1;
                mem_wdata = bit_len[63:32];
            end else if (pad_first_reg) begin
                for (int l = 0; l < 4; l++) begin
                    mem_we[l] = (2'(l) >= pad_lane_reg);
                    mem_wdata[8*l +: 8] = (2'(l) == pad_lane_reg) ? md5_pkg::PAD_BYTE : 8'h00;
                end
            end else begin
                mem_we = '1;
            end
        end
    end

    assign mem_raddr = md5_pkg::word_sel(step_reg[5:0]);

    always_ff @(posedge aclk) begin
        for (int l = 0; l < 4; l++) begin
            if (mem_we[l]) begin
                buf_mem[mem_waddr][8*l +: 8] <= mem_wdata[8*l +: 8];
            end
        end
        rdata_reg <= buf_mem[mem_raddr];
    end

    // One compression step on the word read in the previous cycle
    assign sidx = step_reg[5:0] - 6'd1;

    always_comb begin
        unique case (sidx[5:4])
            2'd0:    f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
            2'd1:    f_val = (work_reg[1] & work_reg[3]) | (work_reg[2] & ~work_reg[3]);
            2'd2:    f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
            default: f_val = work_reg[2] ^ (work_reg[1] | ~work_reg[3]);
        endcase
        t_val    = work_reg[0] + f_val + rdata_reg + md5_pkg::STEP_CONST[sidx];
        rot_wide = {t_val, t_val} << md5_pkg::rot_amount(sidx);
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_word[k] = chain_reg[k] + work_reg[k];
        end
    end

    // Sequencer and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            step_reg        <= '0;
            pad_word_reg    <= '0;
            pad_lane_reg    <= '0;
            pad_first_reg   <= 1'b0;
            len_blk_reg     <= 1'b0;
            need_second_reg <= 1'b0;
            fin_reg         <= 1'b0;
            out_idx_reg     <= '0;
            out_valid_reg   <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                chain_reg[k] <= md5_pkg::INIT_WORDS[k];
            end
        end else begin
            // digest words leave one per transaction
            if (out_valid_reg && m_ready) begin
                out_idx_reg <= out_idx_reg + 2'd1;
                if (out_idx_reg == 2'd3) begin
                    out_valid_reg <= 1'b0;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        if (q_item.kind == md5_pkg::ITEM_ABSORB) begin
                            count_reg <= count_reg + 61'd1;
                            if (pos == 6'd63) begin
                                fin_reg   <= 1'b0;
                                step_reg  <= '0;
                                state_reg <= ST_COMP;
                            end
                        end else begin
                            fin_reg         <= 1'b1;
                            pad_word_reg    <= pos[5:2];
                            pad_lane_reg    <= pos[1:0];
                            pad_first_reg   <= 1'b1;
                            len_blk_reg     <= (pos[5:3] != 3'd7);
                            need_second_reg <= (pos[5:3] == 3'd7);
                            state_reg       <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    pad_first_reg <= 1'b0;
                    pad_word_reg  <= pad_word_reg + 4'd1;
                    if (pad_word_reg == 4'd15) begin
                        step_reg  <= '0;
                        state_reg <= ST_COMP;
                    end
                end
                ST_COMP: begin
                    if (step_reg == 7'd0) begin
                        for (int k = 0; k < 4; k++) begin
                            work_reg[k] <= chain_reg[k];
                        end
                    end else begin
                        work_reg[0] <= work_reg[3];
                        work_reg[3] <= work_reg[2];
                        work_reg[2] <= work_reg[1];
                        work_reg[1] <= work_reg[1] + rot_wide[63:32];
                    end
                    step_reg <= step_reg + 7'd1;
                    if (step_reg == 7'(md5_pkg::STEPS)) begin
                        state_reg <= ST_FINAL;
                    end
                end
                ST_FINAL: begin
                    state_reg <= ST_IDLE;
                    if (fin_reg && need_second_reg) begin
                        for (int k = 0; k < 4; k++) begin
                            chain_reg[k] <= sum_word[k];
                        end
                        need_second_reg <= 1'b0;
                        len_blk_reg     <= 1'b1;
                        pad_first_reg   <= 1'b0;
                        pad_word_reg    <= '0;
                        state_reg       <= ST_PAD;
                    end else if (fin_reg) begin
                        // digest ready: hand it to the output, start a new message
                        for (int k = 0; k < 4; k++) begin
                            out_word_reg[k] <= sum_word[k];
                            chain_reg[k]    <= md5_pkg::INIT_WORDS[k];
                        end
                        out_idx_reg   <= '0;
                        out_valid_reg <= 1'b1;
                        count_reg     <= '0;
                        fin_reg       <= 1'b0;
                    end else begin
                        for (int k = 0; k < 4; k++) begin
                            chain_reg[k] <= sum_word[k];
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_digest_word = out_word_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == 2'd3);

endmodule

/* src/md5_message_digest_top.sv */
// MD5 digest engine, one message byte per input transaction.
//
// Input channel (s_valid/s_ready): s_action = 0 absorbs s_data_byte,
// s_action = 1 finishes the message (s_data_byte ignored).
// Output channel (m_valid/m_ready): on each finish, four transactions
// carry chaining words A, B, C, D (m_word_index 0..3, m_last_word on D);
// the digest bytes are the little-endian bytes of each word, A first.
// A four-entry queue takes input transactions while the engine works.
// An absorb stores its byte in the block buffer; the 64th byte of a block
// adds a compression (a load, 64 steps, a fold into the chaining words).
// A finish writes the padding one buffer word per cycle and compresses,
// twice if no more than 8 bytes of the block remain. With an idle engine
// word A shows once the last compression is folded in; the words then
// leave one per cycle while m_ready is high. Otherwise the input takes
// one byte per cycle; the pauses come from the single step unit and the
// single block buffer. While m_ready is low the digest waits in its
// output register; bytes of the next message are still absorbed, and a
// second finish waits until the words have left. Reset clears the
// queue and output, loads the standard initial words and zeroes the
// byte count; the buffer is kept.
module md5_message_digest_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic         s_action,
    input  logic [7:0]   s_data_byte,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [31:0]  m_digest_word,
    output logic [1:0]   m_word_index,
    output logic         m_last_word
);

    logic             q_valid;
    logic             q_pop;
    md5_pkg::item_t   q_item;

    md5_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    md5_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last_word   (m_last_word)
    );

endmodule

/* src/md5_checker.sv */
module md5_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [31:0]  m_digest_word,
    input  logic [1:0]   m_word_index,
    input  logic         m_last_word
);

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digest_word) && $stable(m_word_index))
        else $error("result changed while stalled");

    // Words of one digest follow each other without a gap
    a_word_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_word |=>
            m_valid && (m_word_index == 2'($past(m_word_index) + 2'd1)))
        else $error("digest words out of order");

    // Last flag marks word D only
    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_word == (m_word_index == 2'd3)))
        else $error("last flag on wrong word");

    // A digest starts at word A
    a_first_word: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> (m_word_index == 2'd0))
        else $error("digest does not start at word A");

    // Reset empties the output
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind md5_message_digest_top md5_checker u_md5_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_digest_word (m_digest_word),
    .m_word_index  (m_word_index),
    .m_last_word   (m_last_word)
);
